/* src/pps_pkg.sv */
// Package: step codes, step action table and shared state types for the sequencer.
package pps_pkg;

  localparam int unsigned SensW  = 8;
  localparam int unsigned ActW   = 8;
  localparam int unsigned TickW  = 16;
  localparam int unsigned DelayW = 24;
  localparam int unsigned TenthW = 7;

  // Sensor bits
  localparam int unsigned SenL1 = 0;
  localparam int unsigned SenL2 = 1;
  localparam int unsigned SenCs = 4;
  localparam int unsigned SenAp = 5;
  localparam int unsigned SenDe = 7;

  // Actuator masks
  localparam logic [ActW-1:0] ActCp = 8'h03;
  localparam logic [ActW-1:0] ActC1 = 8'h04;
  localparam logic [ActW-1:0] ActC2 = 8'h08;
  localparam logic [ActW-1:0] ActPv = 8'h10;
  localparam logic [ActW-1:0] ActPa = 8'h20;
  localparam logic [ActW-1:0] ActAa = 8'h40;
  localparam logic [ActW-1:0] ActGa = 8'h80;

  typedef enum logic [4:0] {
    ST_CHECK          = 5'd0,
    ST_PLUNGE_DN      = 5'd1,
    ST_VAC_ON         = 5'd2,
    ST_PLUNGE_UP      = 5'd3,
    ST_CARR_C1        = 5'd4,
    ST_CARR_WAIT      = 5'd5,
    ST_RELEASE_C1     = 5'd6,
    ST_GRIP           = 5'd7,
    ST_SWING          = 5'd8,
    ST_ARM_WAIT       = 5'd9,
    ST_DROP_C2        = 5'd10,
    ST_WAIT_L1        = 5'd11,
    ST_LEN_CHECK      = 5'd12,
    ST_REJ_CARR       = 5'd13,
    ST_REJ_C2_OFF     = 5'd14,
    ST_REJ_PLUNGE_DN  = 5'd15,
    ST_REJ_VAC        = 5'd16,
    ST_REJ_TO_BIN     = 5'd17,
    ST_REJ_CARR_WAIT  = 5'd18,
    ST_REJ_PLUNGE_DN2 = 5'd19,
    ST_REJ_RELEASE    = 5'd20,
    ST_PAUSE          = 5'd21,
    ST_GOOD_WAIT      = 5'd22,
    ST_ALL_OFF        = 5'd23,
    ST_HALT           = 5'd24
  } step_t;

  typedef struct packed {
    logic [ActW-1:0]   clr;
    logic [ActW-1:0]   set;
    logic [TenthW-1:0] tenths;
  } step_act_t;

  typedef struct packed {
    step_t             step;
    logic [DelayW-1:0] delay;
    logic [ActW-1:0]   act;
    logic              good;
    logic              stopped;
  } pps_state_t;

  typedef struct packed {
    logic [ActW-1:0] act;
    logic            good;
    logic            verdict;
    logic            halted;
  } pps_result_t;

  function automatic step_act_t step_action(input step_t s);
    step_act_t a;
    a = '{clr: '0, set: '0, tenths: '0};
    case (s)
      ST_PLUNGE_DN:      a = '{clr: ActPa, set: ActPa, tenths: 7'd10};
      ST_VAC_ON:         a = '{clr: ActPv, set: ActPv, tenths: 7'd10};
      ST_PLUNGE_UP:      a = '{clr: ActPa, set: 8'h00, tenths: 7'd10};
      ST_CARR_C1:        a = '{clr: ActCp, set: 8'h01, tenths: 7'd10};
      ST_RELEASE_C1:     a = '{clr: ActPv, set: ActC1, tenths: 7'd80};
      ST_GRIP:           a = '{clr: ActC1, set: ActGa, tenths: 7'd10};
      ST_SWING:          a = '{clr: ActAa, set: ActAa, tenths: 7'd10};
      ST_DROP_C2:        a = '{clr: ActGa, set: ActC2, tenths: 7'd20};
      ST_REJ_CARR:       a = '{clr: ActCp, set: 8'h03, tenths: 7'd22};
      ST_REJ_C2_OFF:     a = '{clr: ActC2, set: 8'h00, tenths: 7'd0};
      ST_REJ_PLUNGE_DN:  a = '{clr: ActPa, set: ActPa, tenths: 7'd10};
      ST_REJ_VAC:        a = '{clr: ActPa, set: ActPv, tenths: 7'd10};
      ST_REJ_TO_BIN:     a = '{clr: ActCp, set: 8'h02, tenths: 7'd10};
      ST_REJ_PLUNGE_DN2: a = '{clr: ActPa, set: ActPa, tenths: 7'd10};
      ST_REJ_RELEASE:    a = '{clr: ActPv | ActPa | ActCp, set: 8'h00, tenths: 7'd0};
      ST_PAUSE:          a = '{clr: 8'h00, set: 8'h00, tenths: 7'd10};
      ST_GOOD_WAIT:      a = '{clr: 8'h00, set: 8'h00, tenths: 7'd50};
      ST_ALL_OFF:        a = '{clr: 8'hFF, set: 8'h00, tenths: 7'd30};
      default:           a = '{clr: '0, set: '0, tenths: '0};
    endcase
    return a;
  endfunction

endpackage

/* src/pps_step_ctrl.sv */
// Step sequencer next-state logic: one sensor word in, next machine state out.
module pps_step_ctrl import pps_pkg::*; (
  input  pps_state_t        cur,
  input  logic [SensW-1:0]  sensor,
  input  logic [TickW-1:0]  ticks,
  output pps_state_t        nxt,
  output logic              verdict
);

  step_t     step_nxt;
  logic      enter;
  logic      dec;
  logic      halt_set;
  logic      good_clr;
  logic      good_set;
  logic      good_val;
  step_act_t act_ent;
  logic [TenthW+TickW-1:0] dly_prod;

  logic l1, l2, cs, ap, de;
  assign l1 = sensor[SenL1];
  assign l2 = sensor[SenL2];
  assign cs = sensor[SenCs];
  assign ap = sensor[SenAp];
  assign de = sensor[SenDe];

  // Next step and step events
  always_comb begin
    step_nxt = cur.step;
    enter    = 1'b0;
    dec      = 1'b0;
    halt_set = 1'b0;
    good_clr = 1'b0;
    good_set = 1'b0;
    good_val = 1'b0;
    verdict  = 1'b0;
    unique case (cur.step)
      ST_CHECK: begin
        if (de) begin
          step_nxt = ST_HALT;
          halt_set = 1'b1;
        end else begin
          step_nxt = ST_PLUNGE_DN;
          good_clr = 1'b1;
          enter    = 1'b1;
        end
      end
      ST_HALT: begin
        step_nxt = ST_HALT;
      end
      ST_CARR_WAIT, ST_REJ_C2_OFF, ST_REJ_CARR_WAIT, ST_REJ_RELEASE: begin
        if (!cs) begin
          step_nxt = step_t'(cur.step + 5'd1);
          enter    = 1'b1;
        end
      end
      ST_ARM_WAIT: begin
        if (!ap) begin
          step_nxt = ST_DROP_C2;
          enter    = 1'b1;
        end
      end
      ST_WAIT_L1: begin
        if (l1) begin
          step_nxt = ST_LEN_CHECK;
          enter    = 1'b1;
        end
      end
      ST_LEN_CHECK: begin
        if (!(l1 && !l2)) begin
          verdict  = 1'b1;
          good_set = 1'b1;
          good_val = !l1 && !l2;
          step_nxt = (!l1 && !l2) ? ST_GOOD_WAIT : ST_REJ_CARR;
          enter    = 1'b1;
        end
      end
      ST_PLUNGE_DN, ST_VAC_ON, ST_PLUNGE_UP, ST_CARR_C1, ST_RELEASE_C1, ST_GRIP,
      ST_SWING, ST_DROP_C2, ST_REJ_CARR, ST_REJ_PLUNGE_DN, ST_REJ_VAC,
      ST_REJ_TO_BIN, ST_REJ_PLUNGE_DN2, ST_PAUSE, ST_GOOD_WAIT, ST_ALL_OFF: begin
        if (cur.delay <= DelayW'(1)) begin
          enter = 1'b1;
          if (cur.step == ST_PAUSE || cur.step == ST_GOOD_WAIT) begin
            step_nxt = ST_ALL_OFF;
          end else if (cur.step == ST_ALL_OFF) begin
            step_nxt = ST_CHECK;
          end else begin
            step_nxt = step_t'(cur.step + 5'd1);
          end
        end else begin
          dec = 1'b1;
        end
      end
      default: begin
        step_nxt = ST_CHECK;
      end
    endcase
  end

  assign act_ent  = step_action(step_nxt);
  assign dly_prod = (TenthW+TickW)'(act_ent.tenths) * (TenthW+TickW)'(ticks);

  // Actions taken on step entry, delay countdown and flags
  always_comb begin
    nxt      = cur;
    nxt.step = step_nxt;
    if (halt_set) begin
      nxt.act     = '0;
      nxt.stopped = 1'b1;
    end
    if (good_clr) begin
      nxt.good = 1'b0;
    end
    if (good_set) begin
      nxt.good = good_val;
    end
    if (dec) begin
      nxt.delay = cur.delay - DelayW'(1);
    end
    // Entering the dispenser check leaves actuators and delay untouched
    if (enter && step_nxt != ST_CHECK) begin
      nxt.act   = (cur.act & ~act_ent.clr) | act_ent.set;
      nxt.delay = DelayW'(dly_prod);
    end
  end

endmodule

/* src/pps_out_stage.sv */
// Result register with valid/ready handshake toward the downstream receiver.
module pps_out_stage import pps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  pps_result_t res,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        can_load,
  output pps_result_t out_res
);

  logic        valid_r, valid_nxt;
  pps_result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* src/pick_place_sort_sequencer.sv */
// Top level of the pick, place and sort sequencer.
//
// Usage: every accepted input word is one machine tick carrying the sensor
// byte (bit0 L1, bit1 L2, bit4 carriage moving, bit5 arm moving, bit7
// dispenser empty). For each input word exactly one result word comes out:
// the actuator byte after this tick's update, the latest length verdict,
// a one-tick verdict_valid pulse and the halted flag.
// Result: a result word is registered and valid in the cycle after its input word is taken.
// Throughput: one word per cycle unless the output stalls; the step decode,
// entry actions and delay multiply all sit between the sequencer state register
// and the result register, so nothing iterates.
// Stall: in_ready drops only while a result waits and out_ready is low; the
// held result keeps its value and the sequencer state does not advance.
// Config: cfg_ticks_per_tenth sets ticks per tenth of a second (reset 1);
// write it only while the block is idle. The port always accepts.
// Reset: rst_n (synchronous, active low) puts the sequencer at the
// dispenser check with all actuators off and no result pending.
module pick_place_sort_sequencer import pps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SensW-1:0] in_sensor_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ActW-1:0]  out_actuator_byte,
  output logic             out_piece_good,
  output logic             out_verdict_valid,
  output logic             out_halted,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TickW-1:0] cfg_ticks_per_tenth
);

  pps_state_t       st_r, st_nxt;
  logic [TickW-1:0] ticks_r;
  logic             in_acc;
  logic             verdict;
  logic             can_load;
  pps_result_t      res, out_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign in_acc    = in_valid && in_ready;

  // Tick scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TickW'(1);
    end else if (cfg_valid && cfg_ready) begin
      ticks_r <= cfg_ticks_per_tenth;
    end
  end

  pps_step_ctrl u_ctrl (
    .cur     (st_r),
    .sensor  (in_sensor_byte),
    .ticks   (ticks_r),
    .nxt     (st_nxt),
    .verdict (verdict)
  );

  // Advance the sequencer only on an accepted word; hold it otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{step: ST_CHECK, delay: '0, act: '0, good: 1'b0, stopped: 1'b0};
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  assign res = '{act: st_nxt.act, good: st_nxt.good, verdict: verdict,
                 halted: st_nxt.stopped};

  pps_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .out_res   (out_res)
  );

  assign out_actuator_byte = out_res.act;
  assign out_piece_good    = out_res.good;
  assign out_verdict_valid = out_res.verdict;
  assign out_halted        = out_res.halted;

  // A halted machine reports all actuators off
  a_halt_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> out_actuator_byte == '0)
    else $error("halted result with actuators on");

  // Stopping is permanent until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stopped |=> st_r.stopped)
    else $error("stopped flag cleared");

  // A completed length check branches to good pause or reject sequence
  a_verdict_branch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && verdict |=> (st_r.step == ST_GOOD_WAIT || st_r.step == ST_REJ_CARR))
    else $error("length verdict took a wrong branch");

  // A verdict only comes from the length check step
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    verdict |-> st_r.step == ST_LEN_CHECK)
    else $error("verdict outside length check");

endmodule
